// ===== hdl/mr2u_pkg.sv =====
// shared types, constants and the code point table for the macroman to utf-8 converter
package mr2u_pkg;

    // special byte codes
    localparam logic [7:0] C_CR        = 8'h0D;
    localparam logic [7:0] C_LF        = 8'h0A;
    localparam logic [7:0] C_DQUOTE    = 8'h22;
    localparam logic [7:0] C_SQUOTE    = 8'h27;
    localparam logic [7:0] C_SLASH     = 8'h2F;
    localparam logic [7:0] C_BSLASH    = 8'h5C;
    localparam logic [7:0] C_CURLY_OPN = 8'hD2;
    localparam logic [7:0] C_COMMENT   = 8'hC7;
    localparam logic [7:0] C_DROP      = 8'hC8;
    localparam logic [7:0] C_LEAD3     = 8'hE0;
    localparam logic [7:0] C_LEAD2     = 8'hC0;
    localparam logic [7:0] C_CONT      = 8'h80;
    localparam logic [15:0] C_CURLY_CLS = 16'h201D;
    localparam logic [15:0] C_CP_3BYTE  = 16'h0800;

    // queue geometry
    localparam int C_Q_DEPTH = 4;
    localparam int C_Q_AW    = $clog2(C_Q_DEPTH);

    // one queued unit: up to three output bytes and how many of them are used
    typedef struct packed {
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
        logic [1:0] cnt;
    } t_entry;

    // code points of bytes 0x80 to 0xff
    localparam logic [15:0] C_MR_ROM [0:127] = '{
        16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
        16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
        16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
        16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
        16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
        16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
        16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
        16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
        16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
        16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
        16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
        16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
        16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
        16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
        16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
        16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
    };

endpackage

// ===== hdl/macroman_to_utf8_literal_aware.sv =====
// top level of the literal-aware macroman to utf-8 converter
//
//  channel | dir | tdata           | tlast
//  s_axis  | in  | [7:0] in_byte   | end_of_text
//  m_axis  | out | [7:0] out_byte  | last_of_run
//
//  one output word per cycle while tready is high; an input word yields zero to three
//  output words; an input word is taken each cycle while the four-unit queue has room
//  the output side is fed straight from the queue head, so steady rate is set by
//  the number of utf-8 bytes sent, one per cycle on the output port while tready is high
//  synchronous active-low reset clears literal state, queue and byte index
//  a stalled output keeps its word; the input side keeps running until the queue fills
module macroman_to_utf8_literal_aware import mr2u_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);

    logic   push, pop, full, empty, accept;
    t_entry entry, head;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    // classify and encode
    mr2u_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_eot    (s_axis_tlast),
        .o_push   (push),
        .o_entry  (entry)
    );

    // decoupling queue
    mr2u_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // byte sender
    mr2u_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// ===== hdl/mr2u_front.sv =====
// front end: literal tracking, code point lookup and utf-8 encoding of one input word
module mr2u_front import mr2u_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_eot,
    output logic       o_push,
    output t_entry     o_entry
);

    logic r_str, r_curly, r_chr, r_esc;
    logic n_str, n_curly, n_chr, n_esc;
    logic [15:0] cp;
    t_entry cp_enc;
    logic drop;

    // code point and its utf-8 form
    always_comb begin
        cp = i_byte[7] ? C_MR_ROM[i_byte[6:0]] : {8'h00, i_byte};
        cp_enc = '0;
        if (!i_byte[7]) begin
            cp_enc.b0  = i_byte;
            cp_enc.cnt = 2'd1;
        end else if (cp < C_CP_3BYTE) begin
            cp_enc.b0  = C_LEAD2 | {3'b000, cp[10:6]};
            cp_enc.b1  = C_CONT | {2'b00, cp[5:0]};
            cp_enc.cnt = 2'd2;
        end else begin
            cp_enc.b0  = C_LEAD3 | {4'h0, cp[15:12]};
            cp_enc.b1  = C_CONT | {2'b00, cp[11:6]};
            cp_enc.b2  = C_CONT | {2'b00, cp[5:0]};
            cp_enc.cnt = 2'd3;
        end
    end

    // classification and next literal state
    always_comb begin
        n_str   = r_str;
        n_curly = r_curly;
        n_chr   = r_chr;
        n_esc   = r_esc;
        o_entry = cp_enc;
        drop    = 1'b0;
        if (i_byte == C_CR || i_byte == C_LF) begin
            n_str = 1'b0;
            n_chr = 1'b0;
            n_esc = 1'b0;
            o_entry = '0;
            o_entry.b0  = C_LF;
            o_entry.cnt = 2'd1;
        end else if (r_str || r_chr) begin
            if (r_esc) begin
                n_esc = 1'b0;
            end else if (i_byte == C_BSLASH) begin
                n_esc = 1'b1;
            end else if (r_str) begin
                if (r_curly ? (cp == C_CURLY_CLS) : (i_byte == C_DQUOTE)) begin
                    n_str = 1'b0;
                end
            end else if (i_byte == C_SQUOTE) begin
                n_chr = 1'b0;
            end
        end else if (i_byte == C_DQUOTE) begin
            n_str   = 1'b1;
            n_curly = 1'b0;
        end else if (i_byte == C_CURLY_OPN) begin
            n_str   = 1'b1;
            n_curly = 1'b1;
        end else if (i_byte == C_SQUOTE) begin
            n_chr = 1'b1;
        end else if (i_byte == C_COMMENT) begin
            o_entry = '0;
            o_entry.b0  = C_SLASH;
            o_entry.b1  = C_SLASH;
            o_entry.cnt = 2'd2;
        end else if (i_byte == C_DROP) begin
            drop = 1'b1;
        end
        // end of text returns to the reset state
        if (i_eot) begin
            n_str   = 1'b0;
            n_curly = 1'b0;
            n_chr   = 1'b0;
            n_esc   = 1'b0;
        end
    end

    assign o_push = i_accept && !drop;

    // literal state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_str   <= 1'b0;
            r_curly <= 1'b0;
            r_chr   <= 1'b0;
            r_esc   <= 1'b0;
        end else if (i_accept) begin
            r_str   <= n_str;
            r_curly <= n_curly;
            r_chr   <= n_chr;
            r_esc   <= n_esc;
        end
    end

endmodule

// ===== hdl/mr2u_queue.sv =====
// short queue of encoded units between front and back end
module mr2u_queue import mr2u_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    t_entry r_slot [C_Q_DEPTH];
    logic [C_Q_AW-1:0] r_wr, r_rd;
    logic [C_Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (C_Q_AW+1)'(C_Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_slot[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hdl/mr2u_back.sv =====
// back end: sends the bytes of the head unit one word per cycle while i_tready is high
module mr2u_back import mr2u_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_entry     i_head,
    output logic       o_pop,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic       o_tlast
);

    logic [1:0] r_idx;
    logic       xfer;

    assign o_tvalid = !i_empty;
    assign xfer     = o_tvalid && i_tready;
    assign o_tlast  = (r_idx == i_head.cnt - 2'd1);
    assign o_pop    = xfer && o_tlast;

    // byte select within the unit
    always_comb begin
        case (r_idx)
            2'd0:    o_tdata = i_head.b0;
            2'd1:    o_tdata = i_head.b1;
            default: o_tdata = i_head.b2;
        endcase
    end

    // byte index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (xfer) begin
            r_idx <= o_tlast ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule
